### rtl/xcsg_pkg.sv
package xcsg_pkg;

  // Lattice limits and field widths
  localparam int MAX_SIDE = 16;
  localparam int COORD_W  = 4;
  localparam int SIZE_W   = 5;
  localparam int IDX_W    = 14;
  localparam int SXY_W    = 9;   // up to MAX_SIDE^2
  localparam int N_W      = 13;  // up to MAX_SIDE^3
  localparam int YT_W     = COORD_W + SIZE_W;
  localparam int ZT_W     = COORD_W + SXY_W;
  localparam int STEP_W   = 4;

  // Size register indexes
  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;

  // Stabilizer kinds
  localparam logic [1:0] ACT_XY   = 2'd0;
  localparam logic [1:0] ACT_XZ   = 2'd1;
  localparam logic [1:0] ACT_YZ   = 2'd2;
  localparam logic [1:0] ACT_CUBE = 2'd3;

  // Edge orientations
  localparam logic [1:0] ORIENT_X = 2'd0;
  localparam logic [1:0] ORIENT_Y = 2'd1;
  localparam logic [1:0] ORIENT_Z = 2'd2;

  // Last step of a request
  localparam logic [STEP_W-1:0] VERTEX_LAST = 4'd3;
  localparam logic [STEP_W-1:0] CUBE_LAST   = 4'd11;

  // Classified request, as queued between front and back
  typedef struct packed {
    logic [1:0]         act;
    logic               bad;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] xo;   // x+1 for a cube, x-1 for a vertex (wrapped)
    logic [YT_W-1:0]    yt;   // y * sx
    logic [YT_W-1:0]    yot;  // wrapped y neighbor * sx
    logic [ZT_W-1:0]    zt;   // z * sx * sy
    logic [ZT_W-1:0]    zot;  // wrapped z neighbor * sx * sy
    logic [IDX_W-1:0]   v;    // linear site index
  } entry_t;

  // Queue read side toward the back end
  typedef struct packed {
    logic   valid;
    entry_t data;
  } q_out_t;

endpackage

### rtl/xcsg_front.sv
module xcsg_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 action,
  input  logic [xcsg_pkg::COORD_W-1:0] coord_x,
  input  logic [xcsg_pkg::COORD_W-1:0] coord_y,
  input  logic [xcsg_pkg::COORD_W-1:0] coord_z,
  input  logic [xcsg_pkg::SIZE_W-1:0]  sx,
  input  logic [xcsg_pkg::SIZE_W-1:0]  sy,
  input  logic [xcsg_pkg::SIZE_W-1:0]  sz,
  input  logic [xcsg_pkg::SXY_W-1:0]   sxy,
  input  logic                       q_full,
  output logic                       push,
  output xcsg_pkg::entry_t           push_data
);
  import xcsg_pkg::*;

  logic               f_valid;
  logic [1:0]         f_act;
  logic [COORD_W-1:0] f_x, f_y, f_z;
  logic               is_cube;
  logic [COORD_W-1:0] xo, yo, zo;

  assign in_stall = f_valid && q_full;
  assign push     = f_valid && !q_full;

  // Register the request and hold it until it is pushed
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      f_act <= action;
      f_x   <= coord_x;
      f_y   <= coord_y;
      f_z   <= coord_z;
    end
  end

  // Wrapped neighbor: +1 for a cube, -1 for a vertex
  function automatic logic [COORD_W-1:0] nb(input logic [COORD_W-1:0] c,
                                            input logic [SIZE_W-1:0] s,
                                            input logic up);
    logic [SIZE_W-1:0] cp;
    logic [SIZE_W-1:0] sm;
    cp = {1'b0, c} + 1'b1;
    sm = s - 1'b1;
    if (up) begin
      nb = (cp >= s) ? '0 : cp[COORD_W-1:0];
    end else begin
      nb = (c == '0) ? sm[COORD_W-1:0] : c - 1'b1;
    end
  endfunction

  // Classify: range check, neighbors and partial products
  always_comb begin
    is_cube = (f_act == ACT_CUBE);
    xo = nb(f_x, sx, is_cube);
    yo = nb(f_y, sy, is_cube);
    zo = nb(f_z, sz, is_cube);
    push_data.act = f_act;
    push_data.bad = ({1'b0, f_x} >= sx) || ({1'b0, f_y} >= sy) ||
                    ({1'b0, f_z} >= sz);
    push_data.x   = f_x;
    push_data.xo  = xo;
    push_data.yt  = YT_W'(f_y * sx);
    push_data.yot = YT_W'(yo * sx);
    push_data.zt  = ZT_W'(f_z * sxy);
    push_data.zot = ZT_W'(zo * sxy);
    push_data.v   = IDX_W'(f_z * sxy) + IDX_W'(f_y * sx) + IDX_W'(f_x);
  end

endmodule

### rtl/xcsg_queue.sv
module xcsg_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  xcsg_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output xcsg_pkg::q_out_t q_out
);
  import xcsg_pkg::*;

  localparam int DEPTH = 2;

  entry_t     mem [DEPTH];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full        = (count == 2'(DEPTH));
  assign q_out.valid = (count != '0);
  assign q_out.data  = mem[rd_ptr];

  // Store incoming request
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

### rtl/xcsg_back.sv
module xcsg_back (
  input  logic                         clk,
  input  logic                         rst,
  input  xcsg_pkg::q_out_t             q_out,
  output logic                         pop,
  input  logic [xcsg_pkg::N_W-1:0]     n_sites,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         matrix_select,
  output logic [xcsg_pkg::IDX_W-1:0]   row_index,
  output logic [xcsg_pkg::IDX_W-1:0]   qubit_index,
  output logic                         last,
  output logic                         bad_coordinate
);
  import xcsg_pkg::*;

  entry_t            cur;
  logic              cur_valid;
  logic [STEP_W-1:0] step;

  logic              is_cube, last_step, fire, use_o;
  logic [1:0]        orient;
  logic              use_xo, use_yo, use_zo;
  logic [IDX_W-1:0]  n_ext, obase, rbase, q_val, r_val;
  logic [1:0]        grp;

  assign is_cube   = (cur.act == ACT_CUBE);
  assign last_step = cur.bad || (is_cube ? (step == CUBE_LAST) : (step == VERTEX_LAST));
  assign fire      = cur_valid && (!out_valid || !out_stall);
  assign pop       = q_out.valid && (!cur_valid || (fire && last_step));
  assign n_ext     = IDX_W'(n_sites);
  assign grp       = step[3:2];
  assign use_o     = !step[0];

  // Pick the edge for this step
  always_comb begin
    if (is_cube) begin
      orient = grp;
      use_xo = (grp != ORIENT_X) && step[0];
      use_yo = ((grp == ORIENT_X) && step[0]) || ((grp == ORIENT_Z) && step[1]);
      use_zo = (grp != ORIENT_Z) && step[1];
    end else begin
      if (!step[1]) begin
        orient = (cur.act == ACT_YZ) ? ORIENT_Y : ORIENT_X;
      end else begin
        orient = (cur.act == ACT_XY) ? ORIENT_Y : ORIENT_Z;
      end
      use_xo = (orient == ORIENT_X) && use_o;
      use_yo = (orient == ORIENT_Y) && use_o;
      use_zo = (orient == ORIENT_Z) && use_o;
    end

    unique case (orient)
      ORIENT_X: obase = '0;
      ORIENT_Y: obase = n_ext;
      ORIENT_Z: obase = n_ext << 1;
      default:  obase = '0;
    endcase

    unique case (cur.act)
      ACT_XY:   rbase = '0;
      ACT_XZ:   rbase = n_ext;
      ACT_YZ:   rbase = n_ext << 1;
      ACT_CUBE: rbase = '0;
      default:  rbase = '0;
    endcase

    q_val = obase
          + IDX_W'(use_zo ? cur.zot : cur.zt)
          + IDX_W'(use_yo ? cur.yot : cur.yt)
          + IDX_W'(use_xo ? cur.xo : cur.x);
    r_val = rbase + cur.v;
  end

  // Load requests and step through their results
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      step      <= '0;
    end else if (fire) begin
      if (last_step) begin
        cur_valid <= 1'b0;
        step      <= '0;
      end else begin
        step <= step + 1'b1;
      end
    end
    if (pop) begin
      cur <= q_out.data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (fire) begin
      matrix_select  <= is_cube;
      row_index      <= cur.bad ? '0 : r_val;
      qubit_index    <= cur.bad ? '0 : q_val;
      last           <= last_step;
      bad_coordinate <= cur.bad;
    end
  end

endmodule

### rtl/xcube_stabilizer_support_gen_unit.sv
// X-cube stabilizer support generator. Each request (kind, x, y, z) produces
// the qubit support of one stabilizer on a periodic lattice sized by the
// size_x/size_y/size_z registers (values above 16 act as 16): four results
// for a planar vertex check, twelve for a cube check, or a single flagged
// result when a coordinate is not below its size. The back-end sequencer
// emits one result per cycle while the output is not stalled, and loads the
// next queued request as it emits the last result of the one before. Requests are
// registered, classified and queued two deep ahead of the sequencer, so
// new requests are taken while earlier ones are still being emitted.
// Write the size registers only with no request in flight.
module xcube_stabilizer_support_gen_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     action,
  input  logic [xcsg_pkg::COORD_W-1:0]   coord_x,
  input  logic [xcsg_pkg::COORD_W-1:0]   coord_y,
  input  logic [xcsg_pkg::COORD_W-1:0]   coord_z,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           matrix_select,
  output logic [xcsg_pkg::IDX_W-1:0]     row_index,
  output logic [xcsg_pkg::IDX_W-1:0]     qubit_index,
  output logic                           last,
  output logic                           bad_coordinate,
  input  logic                           cfg_write,
  input  logic [1:0]                     cfg_index,
  input  logic [xcsg_pkg::SIZE_W-1:0]    cfg_data
);
  import xcsg_pkg::*;

  localparam logic [SIZE_W-1:0] SIDE_MAX = SIZE_W'(MAX_SIDE);

  logic [SIZE_W-1:0] size_x, size_y, size_z;
  logic [SIZE_W-1:0] sx, sy, sz;
  logic [SXY_W-1:0]  sxy;
  logic [N_W-1:0]    n_sites;
  logic              push, q_full, pop;
  entry_t            push_data;
  q_out_t            q_out;

  // Size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= SIDE_MAX;
      size_y <= SIDE_MAX;
      size_z <= SIDE_MAX;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SIZE_X: size_x <= cfg_data;
        REG_SIZE_Y: size_y <= cfg_data;
        REG_SIZE_Z: size_z <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Clamp sizes
  assign sx = (size_x > SIDE_MAX) ? SIDE_MAX : size_x;
  assign sy = (size_y > SIDE_MAX) ? SIDE_MAX : size_y;
  assign sz = (size_z > SIDE_MAX) ? SIDE_MAX : size_z;

  // Plane and site counts, registered, one multiply per register
  always_ff @(posedge clk) begin
    if (rst) begin
      sxy     <= SXY_W'(MAX_SIDE * MAX_SIDE);
      n_sites <= N_W'(MAX_SIDE * MAX_SIDE * MAX_SIDE);
    end else begin
      sxy     <= SXY_W'(sx * sy);
      n_sites <= N_W'(sxy * sz);
    end
  end

  xcsg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .coord_x   (coord_x),
    .coord_y   (coord_y),
    .coord_z   (coord_z),
    .sx        (sx),
    .sy        (sy),
    .sz        (sz),
    .sxy       (sxy),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  xcsg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_out     (q_out)
  );

  xcsg_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_out          (q_out),
    .pop            (pop),
    .n_sites        (n_sites),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .matrix_select  (matrix_select),
    .row_index      (row_index),
    .qubit_index    (qubit_index),
    .last           (last),
    .bad_coordinate (bad_coordinate)
  );

endmodule

### rtl/xcsg_checker.sv
module xcsg_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         matrix_select,
  input logic [xcsg_pkg::IDX_W-1:0]   row_index,
  input logic [xcsg_pkg::IDX_W-1:0]   qubit_index,
  input logic                         last,
  input logic                         bad_coordinate
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(row_index) &&
      $stable(qubit_index) && $stable(last))
    else $error("stalled result changed");

  // Flagged result is marked last
  a_bad_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_coordinate |-> last)
    else $error("bad coordinate result not last");

  // Flagged result carries zero indexes
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_coordinate |-> row_index == '0 && qubit_index == '0)
    else $error("bad coordinate result has nonzero index");

  // Results of one request follow at once with the same check row
  a_same_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid &&
      row_index == $past(row_index) && matrix_select == $past(matrix_select))
    else $error("request results split or row changed");

endmodule

bind xcube_stabilizer_support_gen_unit xcsg_checker u_chk (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .matrix_select  (matrix_select),
  .row_index      (row_index),
  .qubit_index    (qubit_index),
  .last           (last),
  .bad_coordinate (bad_coordinate)
);

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import xcsg_pkg::*;

  // Index past the register map
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 100;
  localparam int PHASES         = 7;

  typedef struct packed {
    logic [1:0]         kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } request_t;

  typedef struct packed {
    logic             mat;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] qubit;
    logic             last;
    logic             bad;
  } support_t;

  // Expected stabilizer support, one entry per expected result, oldest first
  class support_scoreboard;
    logic [SIZE_W-1:0] size_reg[3];
    support_t          support_q[$];
    int unsigned       errors;
    int unsigned       sx;
    int unsigned       sxy;
    int unsigned       n;
    logic              cur_mat;
    logic [IDX_W-1:0]  cur_row;

    function new();
      size_reg[REG_SIZE_X] = SIZE_W'(MAX_SIDE);
      size_reg[REG_SIZE_Y] = SIZE_W'(MAX_SIDE);
      size_reg[REG_SIZE_Z] = SIZE_W'(MAX_SIDE);
      errors = 0;
    endfunction

    function void set_size(logic [1:0] idx, logic [SIZE_W-1:0] data);
      if (idx != REG_UNUSED) size_reg[idx] = data;
    endfunction

    // Sizes above the lattice limit act as the limit
    function int unsigned side(logic [1:0] idx);
      return (size_reg[idx] > MAX_SIDE) ? MAX_SIDE : size_reg[idx];
    endfunction

    function void push_edge(logic [1:0] orient, int unsigned ex, int unsigned ey,
                            int unsigned ez);
      support_t s;
      s.mat   = cur_mat;
      s.row   = cur_row;
      s.qubit = IDX_W'(orient * n + ez * sxy + ey * sx + ex);
      s.last  = 1'b0;
      s.bad   = 1'b0;
      support_q.push_back(s);
    endfunction

    // Predict the support of one accepted request
    function void note_request(request_t r);
      int unsigned sy, sz, x, y, z, xm, ym, zm, xp, yp, zp;
      int j;
      support_t s;
      sx = side(REG_SIZE_X);
      sy = side(REG_SIZE_Y);
      sz = side(REG_SIZE_Z);
      x = r.x;
      y = r.y;
      z = r.z;
      cur_mat = (r.kind == ACT_CUBE);
      // Out-of-lattice site: single flagged result
      if (x >= sx || y >= sy || z >= sz) begin
        s = '0;
        s.mat  = cur_mat;
        s.last = 1'b1;
        s.bad  = 1'b1;
        support_q.push_back(s);
        return;
      end
      sxy = sx * sy;
      n   = sxy * sz;
      xm = (x == 0) ? sx - 1 : x - 1;
      ym = (y == 0) ? sy - 1 : y - 1;
      zm = (z == 0) ? sz - 1 : z - 1;
      xp = (x + 1 >= sx) ? 0 : x + 1;
      yp = (y + 1 >= sy) ? 0 : y + 1;
      zp = (z + 1 >= sz) ? 0 : z + 1;
      if (r.kind == ACT_CUBE) begin
        cur_row = IDX_W'(z * sxy + y * sx + x);
        for (j = 0; j < 4; j++) push_edge(ORIENT_X, x, j[0] ? yp : y, j[1] ? zp : z);
        for (j = 0; j < 4; j++) push_edge(ORIENT_Y, j[0] ? xp : x, y, j[1] ? zp : z);
        for (j = 0; j < 4; j++) push_edge(ORIENT_Z, j[0] ? xp : x, j[1] ? yp : y, z);
      end else begin
        cur_row = IDX_W'(r.kind * n + z * sxy + y * sx + x);
        if (r.kind != ACT_YZ) begin
          push_edge(ORIENT_X, xm, y, z);
          push_edge(ORIENT_X, x, y, z);
        end
        if (r.kind != ACT_XZ) begin
          push_edge(ORIENT_Y, x, ym, z);
          push_edge(ORIENT_Y, x, y, z);
        end
        if (r.kind != ACT_XY) begin
          push_edge(ORIENT_Z, x, y, zm);
          push_edge(ORIENT_Z, x, y, z);
        end
      end
      s = support_q.pop_back();
      s.last = 1'b1;
      support_q.push_back(s);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("%0t ns  mismatch: %s", $time, msg);
    endtask

    task compare_field(string name, logic [IDX_W-1:0] got, logic [IDX_W-1:0] want);
      if (got !== want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_result(support_t got);
      support_t want;
      if (support_q.size() == 0) begin
        report($sformatf("unexpected result row %0d qubit %0d", got.row, got.qubit));
        return;
      end
      want = support_q.pop_front();
      compare_field("matrix_select", IDX_W'(got.mat), IDX_W'(want.mat));
      compare_field("row_index", got.row, want.row);
      compare_field("qubit_index", got.qubit, want.qubit);
      compare_field("last", IDX_W'(got.last), IDX_W'(want.last));
      compare_field("bad_coordinate", IDX_W'(got.bad), IDX_W'(want.bad));
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         action;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;
  logic [COORD_W-1:0] coord_z;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               matrix_select;
  logic [IDX_W-1:0]   row_index;
  logic [IDX_W-1:0]   qubit_index;
  logic               last;
  logic               bad_coordinate;
  logic               cfg_write;
  logic [1:0]         cfg_index;
  logic [SIZE_W-1:0]  cfg_data;

  support_scoreboard sb = new();
  support_t          got_res;
  bit                quiet = 1'b0;
  int                stall_left = 0;
  int                idle_cycles = 0;

  xcube_stabilizer_support_gen_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .coord_x        (coord_x),
    .coord_y        (coord_y),
    .coord_z        (coord_z),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .matrix_select  (matrix_select),
    .row_index      (row_index),
    .qubit_index    (qubit_index),
    .last           (last),
    .bad_coordinate (bad_coordinate),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short pauses, now and then a long one
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver backpressure
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (quiet || $urandom_range(0, 1) == 0) begin
      out_stall <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b1;
      stall_left <= pause_len();
    end
  end

  // Check results and watch for a hang
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_res.mat   = matrix_select;
      got_res.row   = row_index;
      got_res.qubit = qubit_index;
      got_res.last  = last;
      got_res.bad   = bad_coordinate;
      sb.check_result(got_res);
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t ns  no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic request_t mk(logic [1:0] kind, int x, int y, int z);
    request_t r;
    r.kind = kind;
    r.x = COORD_W'(x);
    r.y = COORD_W'(y);
    r.z = COORD_W'(z);
    return r;
  endfunction

  // Mostly sites inside the lattice, some anywhere in the field range
  function automatic logic [COORD_W-1:0] pick_coord(int unsigned s);
    if (s > 0 && $urandom_range(0, 99) < 85) return COORD_W'($urandom_range(0, s - 1));
    return COORD_W'($urandom_range(0, 15));
  endfunction

  function automatic request_t random_request();
    request_t r;
    r.kind = 2'($urandom_range(0, 3));
    r.x = pick_coord(sb.side(REG_SIZE_X));
    r.y = pick_coord(sb.side(REG_SIZE_Y));
    r.z = pick_coord(sb.side(REG_SIZE_Z));
    return r;
  endfunction

  // Present one request and hold it until taken
  task automatic send_request(request_t r);
    in_valid <= 1'b1;
    action   <= r.kind;
    coord_x  <= r.x;
    coord_y  <= r.y;
    coord_z  <= r.z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic idle_sender(int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every expected result has come
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.support_q.size() != 0) @(posedge clk);
  endtask

  task automatic play(request_t plan[$], bit hold_mid);
    int i;
    for (i = 0; i < plan.size(); i++) begin
      send_request(plan[i]);
      if (hold_mid && i == plan.size() / 2) hold_until_drained();
      else idle_sender(quiet ? 0 : pause_len());
    end
  endtask

  // Write the three sizes, optionally followed by a write past the map
  task automatic program_lattice(logic [SIZE_W-1:0] sx, logic [SIZE_W-1:0] sy,
                                 logic [SIZE_W-1:0] sz, bit with_unused);
    logic [1:0]        regs[4];
    logic [SIZE_W-1:0] vals[4];
    int                i;
    int                count;
    regs = '{REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z, REG_UNUSED};
    vals = '{sx, sy, sz, 5'd31};
    count = with_unused ? 4 : 3;
    for (i = 0; i < count; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.set_size(regs[i], vals[i]);
    end
    cfg_write <= 1'b0;
  endtask

  initial begin
    request_t plan[$];
    int       rand_count[PHASES];
    int       p;
    rand_count = '{40, 30, 25, 10, 40, 35, 40};
    rst       = 1'b1;
    in_valid  = 1'b0;
    action    = ACT_XY;
    coord_x   = '0;
    coord_y   = '0;
    coord_z   = '0;
    cfg_write = 1'b0;
    cfg_index = REG_SIZE_X;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (p = 0; p < PHASES; p++) begin
      plan.delete();
      // Reconfigure only with the block idle
      case (p)
        1: program_lattice(5'd5, 5'd3, 5'd2, 1'b1);
        2: program_lattice(5'd1, 5'd1, 5'd1, 1'b0);
        3: program_lattice(5'd0, 5'd16, 5'd16, 1'b0);
        4: program_lattice(5'd31, 5'd17, 5'd24, 1'b0);
        5: program_lattice(5'd16, 5'd1, 5'd9, 1'b0);
        6: program_lattice(5'd2, 5'd16, 5'd7, 1'b0);
        default: ;
      endcase
      quiet = (p == 4);
      case (p)
        0: begin
          // Origin and far corner for every kind: both wrap directions
          plan.push_back(mk(ACT_XY, 0, 0, 0));
          plan.push_back(mk(ACT_XZ, 0, 0, 0));
          plan.push_back(mk(ACT_YZ, 0, 0, 0));
          plan.push_back(mk(ACT_CUBE, 0, 0, 0));
          plan.push_back(mk(ACT_XY, 15, 15, 15));
          plan.push_back(mk(ACT_XZ, 15, 15, 15));
          plan.push_back(mk(ACT_YZ, 15, 15, 15));
          plan.push_back(mk(ACT_CUBE, 15, 15, 15));
          plan.push_back(mk(ACT_CUBE, 15, 0, 7));
          plan.push_back(mk(ACT_XY, 0, 15, 3));
          plan.push_back(mk(ACT_XZ, 7, 3, 0));
          plan.push_back(mk(ACT_YZ, 3, 0, 15));
        end
        1: begin
          // Each coordinate just at its size, and all at the field maximum
          plan.push_back(mk(ACT_XY, 5, 0, 0));
          plan.push_back(mk(ACT_CUBE, 0, 3, 0));
          plan.push_back(mk(ACT_XZ, 0, 0, 2));
          plan.push_back(mk(ACT_YZ, 15, 15, 15));
        end
        2: begin
          // Single-site lattice: every neighbor is the site itself
          plan.push_back(mk(ACT_CUBE, 0, 0, 0));
          plan.push_back(mk(ACT_XY, 0, 0, 0));
        end
        3: plan.push_back(mk(ACT_XY, 0, 0, 0));     // zero size flags everything
        4: plan.push_back(mk(ACT_CUBE, 15, 15, 15)); // oversize clips to the limit
        default: ;
      endcase
      repeat (rand_count[p]) plan.push_back(random_request());
      play(plan, p != 3);
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clk);
    end

    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
rtl/xcsg_pkg.sv
rtl/xcsg_front.sv
rtl/xcsg_queue.sv
rtl/xcsg_back.sv
rtl/xcube_stabilizer_support_gen_unit.sv
rtl/xcsg_checker.sv
bench/tb_top.sv
